// ===== hw/rtl/pxd_pkg.sv =====
`timescale 1ns / 1ps
package pxd_pkg;

  // Store geometry: one pixel pair per address, address = {row, column}.
  localparam int X_W         = 6;
  localparam int Y_W         = 6;
  localparam int ADDR_W      = X_W + Y_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam logic [6:0] MAX_DIM = 7'd64;

  // YIQ coefficients with 16 fraction bits.
  localparam logic [15:0] KY_R = 16'd19588;
  localparam logic [15:0] KY_G = 16'd38445;
  localparam logic [15:0] KY_B = 16'd7503;
  localparam logic [15:0] KI_R = 16'd39058;
  localparam logic [15:0] KI_G = 16'd17968;
  localparam logic [15:0] KI_B = 16'd21090;
  localparam logic [15:0] KQ_R = 16'd13859;
  localparam logic [15:0] KQ_G = 16'd34250;
  localparam logic [15:0] KQ_B = 16'd20391;
  // Weights of the squared Y, I and Q differences.
  localparam logic [15:0] W_Y = 16'd33115;
  localparam logic [15:0] W_I = 16'd19595;
  localparam logic [15:0] W_Q = 16'd12825;
  localparam logic [15:0] MAX_YIQ_DELTA = 16'd35215;
  localparam logic [12:0] COUNT_MAX = 13'd8191;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_EVAL  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_IGNORE_AA = 2'd3
  } cfg_reg_t;

  // What the front end decided an item is.
  typedef enum logic [1:0] {
    K_LOAD  = 2'd0,
    K_EVAL  = 2'd1,
    K_CLEAR = 2'd2,
    K_SKIP  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [6:0] w;
    logic [6:0] h;
  } dims_t;

  typedef struct packed {
    dims_t       dims;
    logic [15:0] thr;
    logic        aa;
  } cfg_t;

  typedef struct packed {
    kind_t            kind;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [31:0]      pix_a;
    logic [31:0]      pix_b;
  } item_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        diff;
    logic        aa;
    logic [12:0] count;
  } res_t;

  function automatic logic [6:0] clamp_dim(input logic [6:0] v);
    logic [6:0] r;
    r = v;
    if (v == 7'd0) r = 7'd1;
    else if (v > MAX_DIM) r = MAX_DIM;
    return r;
  endfunction

  // 255 - ceil((255-c)*a/255); the division by 255 is done with adds and a shift.
  function automatic logic [7:0] blend_white(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] v;
    logic [16:0] s;
    v = {8'd0, 8'd255 - c} * {8'd0, a} + 16'd254;
    s = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
    return 8'd255 - s[15:8];
  endfunction

  function automatic logic [23:0] luma(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    return {16'd0, r} * {8'd0, KY_R} + {16'd0, g} * {8'd0, KY_G} +
           {16'd0, b} * {8'd0, KY_B};
  endfunction

  function automatic logic signed [25:0] kmul(input logic signed [8:0] e,
                                              input logic [15:0] k);
    return 26'(e) * $signed({10'd0, k});
  endfunction

  // 255 - ceil((255-gray)/10); the division by ten is a multiply by 205 and a shift.
  function automatic logic [7:0] fade(input logic [7:0] gray);
    logic [8:0]  n;
    logic [19:0] p;
    n = 9'd264 - {1'b0, gray};
    p = {11'd0, n} * 20'd205;
    return 8'd255 - p[18:11];
  endfunction

endpackage

// ===== hw/rtl/perceptual_pixel_diff_with_aa_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  opcode, pixel_x, pixel_y, red_a .. alpha_b
// result    out        out_valid/out_stall  out_red, out_green, out_blue, is_different,
//                                           is_antialiased, diff_count
// config    in         write_enable         reg_index, write_data
//
// Load, clear and unused items are handled in the back end's idle state. An evaluate item
// compares the weighted YIQ difference of its two pixels with the threshold; above it,
// each anti-aliasing sibling test reads one pixel at a time through the image read port
// and its blend and luma stages. Reset clears the queue, the sequencer, the count and the
// configuration registers; the image stores are not cleared. A two-entry queue keeps
// accepting items, until it is full, while the back end works or a result waits on out_stall.
module perceptual_pixel_diff_with_aa_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [5:0]  pixel_x,
  input  logic [5:0]  pixel_y,
  input  logic [7:0]  red_a,
  input  logic [7:0]  green_a,
  input  logic [7:0]  blue_a,
  input  logic [7:0]  alpha_a,
  input  logic [7:0]  red_b,
  input  logic [7:0]  green_b,
  input  logic [7:0]  blue_b,
  input  logic [7:0]  alpha_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        is_different,
  output logic        is_antialiased,
  output logic [12:0] diff_count,
  input  logic        write_enable,
  input  logic [1:0]  reg_index,
  input  logic [15:0] write_data
);
  import pxd_pkg::*;

  logic [6:0]  width_r;
  logic [6:0]  height_r;
  logic [15:0] thr_r;
  logic        aa_r;
  cfg_t        cfg;
  logic        q_valid;
  logic        q_pop;
  item_t       q_item;
  res_t        res;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      width_r  <= 7'd64;
      height_r <= 7'd64;
      thr_r    <= 16'd6554;
      aa_r     <= 1'b1;
    end else if (write_enable) begin
      case (reg_index)
        REG_WIDTH:     width_r  <= write_data[6:0];
        REG_HEIGHT:    height_r <= write_data[6:0];
        REG_THRESHOLD: thr_r    <= write_data;
        REG_IGNORE_AA: aa_r     <= write_data[0];
        default:       aa_r     <= aa_r;
      endcase
    end
  end

  // The image size is used clamped to the range 1 to the store size (64).
  assign cfg.dims.w = clamp_dim(width_r);
  assign cfg.dims.h = clamp_dim(height_r);
  assign cfg.thr    = thr_r;
  assign cfg.aa     = aa_r;

  pxd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .dims     (cfg.dims),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .pixel_x  (pixel_x),
    .pixel_y  (pixel_y),
    .pix_a    ({alpha_a, blue_a, green_a, red_a}),
    .pix_b    ({alpha_b, blue_b, green_b, red_b}),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  pxd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (out_valid),
    .res       (res),
    .out_stall (out_stall)
  );

  assign out_red        = res.red;
  assign out_green      = res.green;
  assign out_blue       = res.blue;
  assign is_different   = res.diff;
  assign is_antialiased = res.aa;
  assign diff_count     = res.count;

endmodule

// ===== hw/rtl/pxd_front.sv =====
`timescale 1ns / 1ps
module pxd_front (
  input  logic            clk,
  input  logic            rst,
  input  pxd_pkg::dims_t  dims,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      opcode,
  input  logic [5:0]      pixel_x,
  input  logic [5:0]      pixel_y,
  input  logic [31:0]     pix_a,
  input  logic [31:0]     pix_b,
  output logic            q_valid,
  output pxd_pkg::item_t  q_item,
  input  logic            q_pop
);
  import pxd_pkg::*;

  item_t      fifo [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  item_t      cls;
  logic       push;

  // Classify the item as it enters so the back end only dispatches.
  always_comb begin
    cls.x     = pixel_x;
    cls.y     = pixel_y;
    cls.pix_a = pix_a;
    cls.pix_b = pix_b;
    case (opcode)
      OP_LOAD:  cls.kind = K_LOAD;
      OP_EVAL:  cls.kind = ({1'b0, pixel_x} < dims.w && {1'b0, pixel_y} < dims.h) ?
                           K_EVAL : K_SKIP;
      OP_CLEAR: cls.kind = K_CLEAR;
      default:  cls.kind = K_SKIP;
    endcase
  end

  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== hw/rtl/pxd_back.sv =====
`timescale 1ns / 1ps
module pxd_back (
  input  logic            clk,
  input  logic            rst,
  input  pxd_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  pxd_pkg::item_t  q_item,
  output logic            q_pop,
  output logic            res_valid,
  output pxd_pkg::res_t   res,
  input  logic            out_stall
);
  import pxd_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'h001,
    S_DRD  = 12'h002,
    S_DW1  = 12'h004,
    S_DW2  = 12'h008,
    S_DW3  = 12'h010,
    S_DW4  = 12'h020,
    S_DCMP = 12'h040,
    S_SRD  = 12'h080,
    S_SW1  = 12'h100,
    S_SW2  = 12'h200,
    S_SUSE = 12'h400,
    S_SRES = 12'h800
  } state_t;

  state_t state, state_next;

  logic [31:0] mem_a [STORE_DEPTH];
  logic [31:0] mem_b [STORE_DEPTH];
  logic [31:0] rd_a, rd_b;
  logic [ADDR_W-1:0] rd_addr;
  logic        mem_we;

  logic [7:0]  ba [3];
  logic [7:0]  bb [3];
  logic [23:0] luma_r;
  logic signed [25:0] dy, di, dq;
  logic [33:0] sq_y, sq_i, sq_q;
  logic [31:0] tt, limit;
  logic [33:0] delta;

  logic [12:0] count, count_next;
  logic [5:0]  ex, ey, cx, cy, nx, ny, lox, loy, hix, hiy;
  logic        scan_img, scan_full, cen_phase, has_neg, has_pos, scan_res;
  logic [1:0]  zeros, sub, sub_next;
  logic        prim, prim_next;
  logic [3:0]  tres, tres_n;
  logic [23:0] centre;
  logic signed [24:0] lo, hi, d;

  logic [5:0]  x0, x2, y0, y2;
  logic        last, at_cen, d_zero, d_neg, d_pos, out_free;
  logic        start_go, st_img, st_full, adv, take_cen, take_nb, fin, fin_res, emit;
  logic [5:0]  st_x, st_y;
  res_t        em;
  logic signed [8:0] e [3];
  logic [24:0] my, mi, mq;
  logic [49:0] wsum;
  logic [47:0] lim_full;

  // Sibling window around the current scan centre, clamped to the image.
  always_comb begin
    x0 = (cx != 6'd0) ? cx - 6'd1 : 6'd0;
    y0 = (cy != 6'd0) ? cy - 6'd1 : 6'd0;
    x2 = ({1'b0, cx} + 7'd1 < cfg.dims.w - 7'd1) ? cx + 6'd1 : 6'(cfg.dims.w - 7'd1);
    y2 = ({1'b0, cy} + 7'd1 < cfg.dims.h - 7'd1) ? cy + 6'd1 : 6'(cfg.dims.h - 7'd1);
  end

  assign last     = (nx == x2) && (ny == y2);
  assign at_cen   = (nx == cx) && (ny == cy);
  assign d        = $signed({1'b0, centre}) - $signed({1'b0, luma_r});
  assign d_zero   = (d == 25'sd0);
  assign d_neg    = d[24];
  assign d_pos    = !d_zero && !d_neg;
  assign out_free = !res_valid || !out_stall;

  always_comb begin
    if (state == S_SRD) rd_addr = cen_phase ? {cy, cx} : {ny, nx};
    else rd_addr = {ey, ex};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_a[{q_item.y, q_item.x}] <= q_item.pix_a;
      mem_b[{q_item.y, q_item.x}] <= q_item.pix_b;
    end
    rd_a <= mem_a[rd_addr];
    rd_b <= mem_b[rd_addr];
  end

  // Free-running arithmetic pipeline behind the read port.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e[i] = $signed({1'b0, ba[i]}) - $signed({1'b0, bb[i]});
    end
    my = dy[25] ? 25'(-dy) : dy[24:0];
    mi = di[25] ? 25'(-di) : di[24:0];
    mq = dq[25] ? 25'(-dq) : dq[24:0];
    wsum = {16'd0, sq_y} * {34'd0, W_Y} + {16'd0, sq_i} * {34'd0, W_I} +
           {16'd0, sq_q} * {34'd0, W_Q};
    lim_full = {16'd0, tt} * {32'd0, MAX_YIQ_DELTA};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ba[i] <= blend_white(rd_a[8*i +: 8], rd_a[31:24]);
      bb[i] <= blend_white(rd_b[8*i +: 8], rd_b[31:24]);
    end
    luma_r <= scan_img ? luma(bb[0], bb[1], bb[2]) : luma(ba[0], ba[1], ba[2]);
    dy <= kmul(e[0], KY_R) + kmul(e[1], KY_G) + kmul(e[2], KY_B);
    di <= kmul(e[0], KI_R) - kmul(e[1], KI_G) - kmul(e[2], KI_B);
    dq <= kmul(e[0], KQ_R) - kmul(e[1], KQ_G) + kmul(e[2], KQ_B);
    sq_y <= 34'(({25'd0, my} * {25'd0, my}) >> 16);
    sq_i <= 34'(({25'd0, mi} * {25'd0, mi}) >> 16);
    sq_q <= 34'(({25'd0, mq} * {25'd0, mq}) >> 16);
    tt    <= {16'd0, cfg.thr} * {16'd0, cfg.thr};
    delta <= wsum[49:16];
    limit <= lim_full[47:16];
  end

  // Sequencer decisions.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    emit       = 1'b0;
    em         = '0;
    count_next = count;
    start_go   = 1'b0;
    st_img     = 1'b0;
    st_full    = 1'b0;
    st_x       = ex;
    st_y       = ey;
    adv        = 1'b0;
    take_cen   = 1'b0;
    take_nb    = 1'b0;
    fin        = 1'b0;
    fin_res    = 1'b0;
    prim_next  = prim;
    sub_next   = sub;
    tres_n     = tres;
    tres_n[sub] = scan_res;

    case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_item.kind)
            K_LOAD:  begin mem_we = 1'b1; emit = 1'b1; end
            K_CLEAR: begin count_next = 13'd0; emit = 1'b1; end
            K_EVAL:  state_next = S_DRD;
            default: emit = 1'b1;
          endcase
        end
      end
      S_DRD: state_next = S_DW1;
      S_DW1: state_next = S_DW2;
      S_DW2: state_next = S_DW3;
      S_DW3: state_next = S_DW4;
      S_DW4: state_next = S_DCMP;
      S_DCMP: begin
        if (out_free) begin
          if (delta > {2'b0, limit}) begin
            if (cfg.aa) begin
              start_go  = 1'b1;
              st_full   = 1'b1;
              prim_next = 1'b0;
            end else begin
              emit = 1'b1;
              em.red = 8'd255;
              em.diff = 1'b1;
              count_next = (count == COUNT_MAX) ? count : count + 13'd1;
            end
          end else begin
            emit = 1'b1;
            em.red   = fade(luma_r[23:16]);
            em.green = fade(luma_r[23:16]);
            em.blue  = fade(luma_r[23:16]);
          end
        end
      end
      S_SRD: begin
        if (cen_phase) begin
          state_next = S_SW1;
        end else if (at_cen) begin
          if (last) begin
            fin = 1'b1;
            fin_res = scan_full ? (has_neg && has_pos) : 1'b1;
          end else begin
            adv = 1'b1;
          end
        end else begin
          state_next = S_SW1;
        end
      end
      S_SW1: state_next = S_SW2;
      S_SW2: state_next = S_SUSE;
      S_SUSE: begin
        if (cen_phase) begin
          take_cen = 1'b1;
          state_next = S_SRD;
        end else begin
          take_nb = 1'b1;
          if (d_zero && zeros == 2'd2) begin
            fin = 1'b1;
          end else if (last) begin
            fin = 1'b1;
            fin_res = scan_full ? ((has_neg || d_neg) && (has_pos || d_pos)) : 1'b1;
          end else begin
            adv = 1'b1;
            state_next = S_SRD;
          end
        end
      end
      S_SRES: begin
        if (out_free) begin
          if (scan_full && scan_res) begin
            start_go = 1'b1;
            sub_next = 2'd0;
            st_img   = prim;
            st_x     = lox;
            st_y     = loy;
          end else if (!scan_full && sub != 2'd3) begin
            start_go = 1'b1;
            sub_next = sub + 2'd1;
            st_img   = prim ^ sub_next[0];
            st_x     = sub_next[1] ? hix : lox;
            st_y     = sub_next[1] ? hiy : loy;
          end else if (!scan_full && ((!tres_n[0] && !tres_n[1]) ||
                                      (!tres_n[2] && !tres_n[3]))) begin
            emit = 1'b1;
            em.red = 8'd255;
            em.green = 8'd255;
            em.aa = 1'b1;
          end else if (!prim) begin
            start_go  = 1'b1;
            st_full   = 1'b1;
            st_img    = 1'b1;
            prim_next = 1'b1;
          end else begin
            emit = 1'b1;
            em.red = 8'd255;
            em.diff = 1'b1;
            count_next = (count == COUNT_MAX) ? count : count + 13'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (fin) state_next = S_SRES;
    if (start_go) state_next = S_SRD;
    if (emit) state_next = S_IDLE;
    em.count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      count     <= 13'd0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (emit) res_valid <= 1'b1;
      else if (!out_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) res <= em;
    if (q_pop) begin
      ex       <= q_item.x;
      ey       <= q_item.y;
      scan_img <= 1'b0;
    end
    prim <= prim_next;
    sub  <= sub_next;
    if (state == S_SRES && !scan_full) tres <= tres_n;
    if (fin) scan_res <= fin_res;
    if (start_go) begin
      scan_img  <= st_img;
      scan_full <= st_full;
      cx        <= st_x;
      cy        <= st_y;
      cen_phase <= 1'b1;
      zeros     <= 2'd0;
      if (st_full) begin
        has_neg <= 1'b0;
        has_pos <= 1'b0;
        lo  <= 25'sd0;
        hi  <= 25'sd0;
        lox <= 6'd0;
        loy <= 6'd0;
        hix <= 6'd0;
        hiy <= 6'd0;
      end
    end
    if (take_cen) begin
      centre    <= luma_r;
      cen_phase <= 1'b0;
      nx        <= x0;
      ny        <= y0;
    end
    if (take_nb) begin
      zeros   <= zeros + {1'b0, d_zero};
      has_neg <= has_neg | d_neg;
      has_pos <= has_pos | d_pos;
      if (scan_full && d < lo) begin
        lo  <= d;
        lox <= nx;
        loy <= ny;
      end
      if (scan_full && d > hi) begin
        hi  <= d;
        hix <= nx;
        hiy <= ny;
      end
    end
    if (adv) begin
      if (ny == y2) begin
        ny <= y0;
        nx <= nx + 6'd1;
      end else begin
        ny <= ny + 6'd1;
      end
    end
  end

endmodule
